/* sv/sgi2d_pkg.sv */
package sgi2d_pkg;

  localparam int VALUE_W         = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int IDX_W           = $clog2(BCD_DIGITS);
  localparam int CHAR_W          = 8;
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // one item on its way through the shift-add-3 pipeline
  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
    logic               neg;
  } stage_t;

  // one double-dabble step: add 3 to every digit of 5 or more, then shift one bit in
  function automatic stage_t dabble_step(stage_t s);
    stage_t     r;
    logic [3:0] d;
    r = s;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = s.bcd[i*4 +: 4];
      if (d >= 4'd5) begin
        r.bcd[i*4 +: 4] = d + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction

endpackage

/* sv/sgi2d_dabble_stage.sv */
module sgi2d_dabble_stage
  import sgi2d_pkg::*;
#(
  parameter int STEPS = STEPS_PER_STAGE
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  input  stage_t up_data,
  output logic   up_ready,
  output logic   dn_valid,
  output stage_t dn_data,
  input  logic   dn_ready
);

  logic   valid_r, valid_nxt;
  stage_t data_r, data_nxt;
  stage_t work;

  always_comb begin
    work = up_data;
    for (int i = 0; i < STEPS; i++) begin
      work = dabble_step(work);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
    data_nxt  = (up_ready && up_valid) ? work : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* sv/sgi2d_serializer.sv */
module sgi2d_serializer
  import sgi2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  stage_t            up_data,
  output logic              up_ready,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char,
  input  logic              out_ready
);

  logic              busy_r, busy_nxt;
  logic              neg_r, neg_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              olast_r, olast_nxt;
  logic [IDX_W-1:0]  top;
  logic              out_free;
  logic              emit;

  // highest nonzero digit, zero gives index 0
  always_comb begin
    top = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (up_data.bcd[i*4 +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign up_ready = !busy_r;
  assign out_free = !ovalid_r || out_ready;
  assign emit     = busy_r && out_free;

  always_comb begin
    busy_nxt   = busy_r;
    neg_nxt    = neg_r;
    idx_nxt    = idx_r;
    bcd_nxt    = bcd_r;
    ovalid_nxt = out_free ? 1'b0 : ovalid_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      if (neg_r) begin
        ochar_nxt = ASCII_MINUS;
        olast_nxt = 1'b0;
        neg_nxt   = 1'b0;
      end else begin
        ochar_nxt = ASCII_ZERO + {4'd0, bcd_r[idx_r*4 +: 4]};
        olast_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end else if (up_valid && up_ready) begin
      busy_nxt = 1'b1;
      neg_nxt  = up_data.neg;
      idx_nxt  = top;
      bcd_nxt  = up_data.bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
    neg_r   <= neg_nxt;
    idx_r   <= idx_nxt;
    bcd_r   <= bcd_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_char_code = ochar_r;
  assign out_last_char = olast_r;

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// the character serializer takes a new number only after sending every character of
//   the last one, and sends one character beat per cycle while out_ready allows it
// the conversion pipeline takes a new number every cycle while it has room
// reset: synchronous active-low rst_n clears all valid bits and the serializer
module signed_int_to_decimal_ascii
  import sgi2d_pkg::*;
#(
  parameter int STEPS = STEPS_PER_STAGE  // double-dabble steps per stage, divides VALUE_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_last_char
);

  localparam int NUM_STAGES = VALUE_W / STEPS;

  // stage 0: sign and magnitude, the unsigned negate covers the most negative value
  logic   s0_valid_r, s0_valid_nxt;
  stage_t s0_data_r, s0_data_nxt;
  stage_t s0_work;

  // pipeline links, index 0 is the stage 0 register
  logic   lk_valid [NUM_STAGES+1];
  stage_t lk_data  [NUM_STAGES+1];
  logic   lk_ready [NUM_STAGES+1];

  always_comb begin
    s0_work.neg = in_value[VALUE_W-1];
    s0_work.bin = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    s0_work.bcd = '0;
  end

  assign in_ready = !s0_valid_r || lk_ready[0];

  always_comb begin
    s0_valid_nxt = in_ready ? in_valid : s0_valid_r;
    s0_data_nxt  = (in_ready && in_valid) ? s0_work : s0_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
    s0_data_r <= s0_data_nxt;
  end

  assign lk_valid[0] = s0_valid_r;
  assign lk_data[0]  = s0_data_r;

  // binary to bcd: shift-add-3 spread over NUM_STAGES registered stages,
  // each stage holding its beat until the next one has room
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sgi2d_dabble_stage #(
      .STEPS (STEPS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lk_valid[g]),
      .up_data  (lk_data[g]),
      .up_ready (lk_ready[g]),
      .dn_valid (lk_valid[g+1]),
      .dn_data  (lk_data[g+1]),
      .dn_ready (lk_ready[g+1])
    );
  end

  // sign, then digits from the leading nonzero one down, through an output register
  sgi2d_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (lk_valid[NUM_STAGES]),
    .up_data       (lk_data[NUM_STAGES]),
    .up_ready      (lk_ready[NUM_STAGES]),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .out_ready     (out_ready)
  );

endmodule
